### design/plsub_pkg.sv
package plsub_pkg;

   localparam int LEN_W              = 16;
   localparam logic [LEN_W-1:0] LEN_RESET = 16'd640;
   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_IDX_W          = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_SEGMENT_LENGTH = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_LEN,
      ST_CHECK,
      ST_STEP_MUL,
      ST_STEP_CMP,
      ST_DIV_X_GO,
      ST_DIV_X_WAIT,
      ST_DIV_Y_GO,
      ST_DIV_Y_WAIT,
      ST_EMIT_INS,
      ST_EMIT_LAST
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_LEN,
      OP_STEP_INIT,
      OP_STEP_MUL,
      OP_STEP_NEXT,
      OP_DIV_X_GO,
      OP_DIV_X_WAIT,
      OP_DIV_Y_GO,
      OP_DIV_Y_WAIT,
      OP_EMIT_INS,
      OP_EMIT_LAST
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic direct;
      logic subdivide;
      logic search_end;
      logic sq_over;
      logic div_done;
      logic k_last;
      logic out_free;
   } status_type;

endpackage

### design/plsub_div.sv
module plsub_div
   import plsub_pkg::*;
#(
   parameter int DVD_W = COORD_BITS_DEFAULT,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder,
   output logic             done
);

   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   rem_shift;
   logic [DVS_W+1:0] rem_diff;
   logic             borrow;

   // one quotient bit per cycle, restoring
   assign rem_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign borrow    = rem_diff[DVS_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = borrow ? rem_shift[DVS_W-1:0] : rem_diff[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ~borrow};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

### design/plsub_ctrl.sv
module plsub_ctrl
   import plsub_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.direct ? ST_EMIT_LAST : ST_SQ_X;
            end
         end
         ST_SQ_X:   state_in = ST_SQ_Y;
         ST_SQ_Y:   state_in = ST_SQ_LEN;
         ST_SQ_LEN: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = status.subdivide ? ST_STEP_MUL : ST_EMIT_LAST;
         end
         ST_STEP_MUL: begin
            state_in = status.search_end ? ST_DIV_X_GO : ST_STEP_CMP;
         end
         ST_STEP_CMP: begin
            state_in = status.sq_over ? ST_DIV_X_GO : ST_STEP_MUL;
         end
         ST_DIV_X_GO: state_in = ST_DIV_X_WAIT;
         ST_DIV_X_WAIT: begin
            if (status.div_done) begin
               state_in = ST_DIV_Y_GO;
            end
         end
         ST_DIV_Y_GO: state_in = ST_DIV_Y_WAIT;
         ST_DIV_Y_WAIT: begin
            if (status.div_done) begin
               state_in = ST_EMIT_INS;
            end
         end
         ST_EMIT_INS: begin
            if (status.out_free && status.k_last) begin
               state_in = ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NONE;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_SQ_X:   cmd.op = OP_SQ_X;
         ST_SQ_Y:   cmd.op = OP_SQ_Y;
         ST_SQ_LEN: cmd.op = OP_SQ_LEN;
         ST_CHECK: begin
            if (status.subdivide) begin
               cmd.op = OP_STEP_INIT;
            end
         end
         ST_STEP_MUL: begin
            if (!status.search_end) begin
               cmd.op = OP_STEP_MUL;
            end
         end
         ST_STEP_CMP: begin
            if (!status.sq_over) begin
               cmd.op = OP_STEP_NEXT;
            end
         end
         ST_DIV_X_GO:   cmd.op = OP_DIV_X_GO;
         ST_DIV_X_WAIT: cmd.op = OP_DIV_X_WAIT;
         ST_DIV_Y_GO:   cmd.op = OP_DIV_Y_GO;
         ST_DIV_Y_WAIT: cmd.op = OP_DIV_Y_WAIT;
         ST_EMIT_INS: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT_INS;
            end
         end
         ST_EMIT_LAST: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT_LAST;
            end
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("transfer accepted but controller stayed idle");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LAST && status.out_free) |=> (state_ff == ST_IDLE))
      else $error("final point written but controller not idle");

endmodule

### design/plsub_dp.sv
module plsub_dp
   import plsub_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [LEN_W-1:0]      max_seg_len,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic                  req_stroke_start,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_out_x,
   output logic [COORD_BITS-1:0] rsp_out_y,
   output logic                  rsp_is_inserted,
   output logic                  rsp_last_of_run
);

   localparam int CW   = COORD_BITS;
   localparam int N_W  = $clog2(MAX_POINTS + 1);
   localparam int T_W  = LEN_W + $clog2(MAX_POINTS);
   localparam int SQ_W = (CW > T_W) ? CW : T_W;
   localparam int P_W  = 2 * SQ_W;
   localparam int D_W  = P_W + 1;
   localparam logic [N_W-1:0] SEARCH_LAST = N_W'(MAX_POINTS - 2);
   localparam logic [N_W-1:0] M_MAX       = N_W'(MAX_POINTS - 1);

   logic [CW-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic           have_prev_ff, have_prev_in;
   logic [CW-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic           negx_ff, negx_in, negy_ff, negy_in;
   logic [P_W-1:0] sq_ff, sq_in;
   logic [D_W-1:0] d2_ff, d2_in;
   logic [T_W-1:0] t_ff, t_in;
   logic [N_W-1:0] m_ff, m_in;
   logic [N_W-1:0] k_ff, k_in;
   logic [CW-1:0]  dqx_ff, dqx_in, dqy_ff, dqy_in;
   logic [N_W-1:0] drx_ff, drx_in, dry_ff, dry_in;
   logic [CW-1:0]  accqx_ff, accqx_in, accqy_ff, accqy_in;
   logic [N_W-1:0] accrx_ff, accrx_in, accry_ff, accry_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic           rsp_ins_ff, rsp_ins_in, rsp_last_ff, rsp_last_in;

   logic [CW:0]     dx_full, dy_full, absx_full, absy_full;
   logic [SQ_W-1:0] sq_opnd;
   logic [P_W-1:0]  sq_prod;
   logic [N_W-1:0]  n_val;
   logic            out_free;
   logic            div_start, div_done;
   logic [CW-1:0]   div_dividend, div_quo;
   logic [N_W-1:0]  div_rem;
   logic [N_W:0]    rsum_x, rsum_y, rnext_x, rnext_y;
   logic            wrap_x, wrap_y;
   logic [CW-1:0]   ins_x, ins_y;

   assign dx_full   = {req_point_x[CW-1], req_point_x} - {prev_x_ff[CW-1], prev_x_ff};
   assign dy_full   = {req_point_y[CW-1], req_point_y} - {prev_y_ff[CW-1], prev_y_ff};
   assign absx_full = dx_full[CW] ? (~dx_full + 1'b1) : dx_full;
   assign absy_full = dy_full[CW] ? (~dy_full + 1'b1) : dy_full;

   always_comb begin
      case (cmd.op)
         OP_SQ_X:     sq_opnd = SQ_W'(ax_ff);
         OP_SQ_Y:     sq_opnd = SQ_W'(ay_ff);
         OP_SQ_LEN:   sq_opnd = SQ_W'(max_seg_len);
         default:     sq_opnd = SQ_W'(t_ff);
      endcase
   end
   assign sq_prod = sq_opnd * sq_opnd;

   assign n_val    = m_ff + 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign div_start    = (cmd.op == OP_DIV_X_GO) || (cmd.op == OP_DIV_Y_GO);
   assign div_dividend = (cmd.op == OP_DIV_X_GO) ? ax_ff : ay_ff;

   plsub_div #(
      .DVD_W(CW),
      .DVS_W(N_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (n_val),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // running k*|d|/n as quotient and remainder
   assign rsum_x  = {1'b0, accrx_ff} + {1'b0, drx_ff};
   assign rsum_y  = {1'b0, accry_ff} + {1'b0, dry_ff};
   assign wrap_x  = (rsum_x >= {1'b0, n_val});
   assign wrap_y  = (rsum_y >= {1'b0, n_val});
   assign rnext_x = wrap_x ? (rsum_x - {1'b0, n_val}) : rsum_x;
   assign rnext_y = wrap_y ? (rsum_y - {1'b0, n_val}) : rsum_y;

   assign ins_x = prev_x_ff + (negx_ff ? (~accqx_ff + 1'b1) : accqx_ff);
   assign ins_y = prev_y_ff + (negy_ff ? (~accqy_ff + 1'b1) : accqy_ff);

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      sq_in        = sq_ff;
      d2_in        = d2_ff;
      t_in         = t_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      dqx_in       = dqx_ff;
      dqy_in       = dqy_ff;
      drx_in       = drx_ff;
      dry_in       = dry_ff;
      accqx_in     = accqx_ff;
      accqy_in     = accqy_ff;
      accrx_in     = accrx_ff;
      accry_in     = accry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_ins_in   = rsp_ins_ff;
      rsp_last_in  = rsp_last_ff;
      case (cmd.op)
         OP_LOAD: begin
            cur_x_in = req_point_x;
            cur_y_in = req_point_y;
            ax_in    = absx_full[CW-1:0];
            ay_in    = absy_full[CW-1:0];
            negx_in  = dx_full[CW];
            negy_in  = dy_full[CW];
         end
         OP_SQ_X: begin
            sq_in = sq_prod;
         end
         OP_SQ_Y: begin
            d2_in = D_W'(sq_ff);
            sq_in = sq_prod;
         end
         OP_SQ_LEN: begin
            d2_in = d2_ff + D_W'(sq_ff);
            sq_in = sq_prod;
            t_in  = T_W'(max_seg_len);
         end
         OP_STEP_INIT: begin
            t_in = t_ff + T_W'(max_seg_len);
            m_in = N_W'(1);
         end
         OP_STEP_MUL: begin
            sq_in = sq_prod;
         end
         OP_STEP_NEXT: begin
            t_in = t_ff + T_W'(max_seg_len);
            m_in = m_ff + 1'b1;
         end
         OP_DIV_X_WAIT: begin
            if (div_done) begin
               dqx_in = div_quo;
               drx_in = div_rem;
            end
         end
         OP_DIV_Y_WAIT: begin
            if (div_done) begin
               dqy_in   = div_quo;
               dry_in   = div_rem;
               accqx_in = dqx_ff;
               accrx_in = drx_ff;
               accqy_in = div_quo;
               accry_in = div_rem;
               k_in     = N_W'(1);
            end
         end
         OP_EMIT_INS: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = ins_x;
            rsp_y_in     = ins_y;
            rsp_ins_in   = 1'b1;
            rsp_last_in  = 1'b0;
            accqx_in     = accqx_ff + dqx_ff + CW'(wrap_x);
            accqy_in     = accqy_ff + dqy_ff + CW'(wrap_y);
            accrx_in     = rnext_x[N_W-1:0];
            accry_in     = rnext_y[N_W-1:0];
            k_in         = k_ff + 1'b1;
         end
         OP_EMIT_LAST: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = cur_x_ff;
            rsp_y_in     = cur_y_ff;
            rsp_ins_in   = 1'b0;
            rsp_last_in  = 1'b1;
            prev_x_in    = cur_x_ff;
            prev_y_in    = cur_y_ff;
            have_prev_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      sq_ff       <= sq_in;
      d2_ff       <= d2_in;
      t_ff        <= t_in;
      m_ff        <= m_in;
      k_ff        <= k_in;
      dqx_ff      <= dqx_in;
      dqy_ff      <= dqy_in;
      drx_ff      <= drx_in;
      dry_ff      <= dry_in;
      accqx_ff    <= accqx_in;
      accqy_ff    <= accqy_in;
      accrx_ff    <= accrx_in;
      accry_ff    <= accry_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_ins_ff  <= rsp_ins_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.direct     = !have_prev_ff || req_stroke_start;
   assign status.subdivide  = (d2_ff > {1'b0, sq_ff});
   assign status.search_end = (m_ff > SEARCH_LAST);
   assign status.sq_over    = ({1'b0, sq_ff} > d2_ff);
   assign status.div_done   = div_done;
   assign status.k_last     = (k_ff == (n_val - 1'b1));
   assign status.out_free   = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_is_inserted = rsp_ins_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT_INS) |-> (k_ff != '0 && k_ff < n_val))
      else $error("inserted point index outside 1..n-1");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_STEP_MUL || cmd.op == OP_STEP_NEXT) |-> (m_ff <= M_MAX))
      else $error("segment count search ran past its limit");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ins_ff != rsp_last_ff))
      else $error("result marked both inserted and last, or neither");

endmodule

### design/polyline_segment_subdivider_core.sv
// A stroke-start point goes from the transfer straight to its result; a short segment first
// squares |dx|, |dy| and the limit. A split segment of n parts adds the n search loop (a multiply
// and a compare state per step) and the shared divider (one bit a cycle) for x and y.
// Input waits until the end point is written; a waiting result does not block the next transfer.
// Reset: previous point cleared to none, segment limit set to 640 (40.0), output empty.
module polyline_segment_subdivider_core
   import plsub_pkg::*;
#(
   parameter int MAX_POINTS_PER_SEGMENT = MAX_POINTS_DEFAULT,
   parameter int COORD_BITS             = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic                  req_stroke_start,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_out_x,
   output logic [COORD_BITS-1:0] rsp_out_y,
   output logic                  rsp_is_inserted,
   output logic                  rsp_last_of_run,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0]     max_len_ff, max_len_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;
   cmd_type              cmd;
   status_type           status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_wr && csr_idx == REG_MAX_SEGMENT_LENGTH) begin
         max_len_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign csr_prdata = (csr_idx == REG_MAX_SEGMENT_LENGTH) ?
                       CSR_DATA_W'(max_len_ff) : '0;

   plsub_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   plsub_dp #(
      .MAX_POINTS (MAX_POINTS_PER_SEGMENT),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .max_seg_len      (max_len_ff),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_stroke_start (req_stroke_start),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_is_inserted  (rsp_is_inserted),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
